@@ rtl/core/linear_probe_hash_set_defines.svh @@
// Assertion macros for the hash set RTL.
`ifndef LINEAR_PROBE_HASH_SET_DEFINES_SVH
`define LINEAR_PROBE_HASH_SET_DEFINES_SVH

`ifndef SYNTHESIS
// cons must hold in the same cycle as ante
`define LPHS_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lphs assertion failed");
// cons must hold in the cycle after ante
`define LPHS_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lphs assertion failed");
`else
`define LPHS_ASSERT_IMP(label, clk, rst, ante, cons)
`define LPHS_ASSERT_NXT(label, clk, rst, ante, cons)
`endif

`endif

@@ rtl/core/lphs_pkg.sv @@
package lphs_pkg;

   localparam int SLOTS_DEFAULT = 1024;
   localparam int KEY_W         = 32;
   localparam int COUNT_W       = 11;
   localparam int MOD_STEPS     = 3;
   localparam int MOD_CNT_W     = 2;
   localparam int CSR_DATA_W    = 32;
   localparam int CSR_ADDR_W    = 2;

   localparam logic [COUNT_W-1:0]    LOAD_LIMIT_RESET = 11'd512;
   localparam logic [CSR_ADDR_W-1:0] ADDR_LOAD_LIMIT  = 2'd0;

   // request kinds
   localparam logic [1:0] ACT_ADD      = 2'd0;
   localparam logic [1:0] ACT_REMOVE   = 2'd1;
   localparam logic [1:0] ACT_CONTAINS = 2'd2;
   localparam logic [1:0] ACT_NONE     = 2'd3;

   // slot marks; the unused code behaves like a tombstone
   localparam logic [1:0] MARK_EMPTY = 2'd0;
   localparam logic [1:0] MARK_FULL  = 2'd1;
   localparam logic [1:0] MARK_TOMB  = 2'd2;

   typedef struct packed {
      logic [1:0]       action;
      logic [KEY_W-1:0] key;
   } req_type;

   typedef struct packed {
      logic               hit;
      logic               refused;
      logic [COUNT_W-1:0] count;
   } rsp_type;

   typedef struct packed {
      logic accept;
      logic clear_step;
      logic prime;
      logic probe;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic clear_last;
      logic mod_done;
      logic probe_stop;
   } sts_type;

endpackage

@@ rtl/core/lphs_mod.sv @@
// key mod SLOTS by reciprocal multiply: the quotient estimate from
// floor(2^32 / SLOTS) is low by at most one, so one compare and subtract
// fixes the remainder. Stages after load: key, quotient, difference, remainder.
module lphs_mod #(
   parameter int SLOTS = lphs_pkg::SLOTS_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      load,
   input  logic [lphs_pkg::KEY_W-1:0] key,
   output logic [$clog2(SLOTS)-1:0]  rem,
   output logic                      done
);

   localparam int IDX_W = $clog2(SLOTS);
   localparam int PROD_W = 2 * lphs_pkg::KEY_W;
   localparam logic [IDX_W:0] SLOTS_V = (IDX_W + 1)'(SLOTS);
   localparam logic [lphs_pkg::KEY_W-1:0] RECIP =
      lphs_pkg::KEY_W'((64'd1 << lphs_pkg::KEY_W) / SLOTS);

   logic [lphs_pkg::KEY_W-1:0]     key_ff, key_in;
   logic [lphs_pkg::KEY_W-1:0]     quot_ff, quot_in;
   logic [IDX_W:0]                 diff_ff, diff_in;
   logic [IDX_W-1:0]               rem_ff, rem_in;
   logic [lphs_pkg::MOD_CNT_W-1:0] cnt_ff, cnt_in;
   logic [PROD_W-1:0]              prod;
   logic [IDX_W:0]                 qd;
   logic [IDX_W:0]                 fixed;

   always_comb begin
      prod    = PROD_W'(key_ff) * PROD_W'(RECIP);
      quot_in = prod[PROD_W-1:lphs_pkg::KEY_W];
      // remainder estimate is below 2*SLOTS, so the low bits are enough
      qd      = quot_ff[IDX_W:0] * SLOTS_V;
      diff_in = key_ff[IDX_W:0] - qd;
      fixed   = diff_ff - SLOTS_V;
      rem_in  = (diff_ff >= SLOTS_V) ? fixed[IDX_W-1:0] : diff_ff[IDX_W-1:0];
      key_in  = key_ff;
      cnt_in  = cnt_ff;
      if (load) begin
         key_in = key;
         cnt_in = lphs_pkg::MOD_CNT_W'(lphs_pkg::MOD_STEPS);
      end else if (cnt_ff != '0) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff  <= key_in;
      quot_ff <= quot_in;
      diff_ff <= diff_in;
      rem_ff  <= rem_in;
   end

   assign rem  = rem_ff;
   assign done = (cnt_ff == '0);

endmodule

@@ rtl/core/lphs_ctrl.sv @@
// Sequencer: clear pass, remainder, probe walk, update.
module lphs_ctrl #(
   parameter int SLOTS = lphs_pkg::SLOTS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [1:0]        req_action,
   input  lphs_pkg::sts_type sts,
   output lphs_pkg::cmd_type cmd,
   output logic              busy
);

   // home slot needs the divider unless SLOTS is a power of two
   localparam bit DIV_NEEDED = ((SLOTS & (SLOTS - 1)) != 0);

   localparam logic [2:0] ST_CLEAR  = 3'd0;
   localparam logic [2:0] ST_IDLE   = 3'd1;
   localparam logic [2:0] ST_MOD    = 3'd2;
   localparam logic [2:0] ST_PRIME  = 3'd3;
   localparam logic [2:0] ST_PROBE  = 3'd4;
   localparam logic [2:0] ST_FINISH = 3'd5;

   logic [2:0] state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (sts.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               cmd.accept = 1'b1;
               if (req_action == lphs_pkg::ACT_NONE) begin
                  state_in = ST_FINISH;
               end else if (DIV_NEEDED) begin
                  state_in = ST_MOD;
               end else begin
                  state_in = ST_PRIME;
               end
            end
         end
         ST_MOD: begin
            if (sts.mod_done) begin
               state_in = ST_PRIME;
            end
         end
         ST_PRIME: begin
            cmd.prime = 1'b1;
            state_in  = ST_PROBE;
         end
         ST_PROBE: begin
            cmd.probe = 1'b1;
            if (sts.probe_stop) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            cmd.finish = 1'b1;
            state_in   = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

@@ rtl/core/lphs_dp.sv @@
// Slot memories, probe registers, element count and result register.
module lphs_dp #(
   parameter int SLOTS = lphs_pkg::SLOTS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  lphs_pkg::cmd_type               cmd,
   input  lphs_pkg::req_type               req_data,
   input  logic [lphs_pkg::COUNT_W-1:0]    load_limit,
   output lphs_pkg::sts_type               sts,
   output lphs_pkg::rsp_type               rsp_data,
   output logic                            rsp_strobe
);

   localparam int IDX_W = $clog2(SLOTS);
   localparam bit POW2  = ((SLOTS & (SLOTS - 1)) == 0);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

   logic [1:0] marks_mem [SLOTS];
   logic [lphs_pkg::KEY_W-1:0] keys_mem [SLOTS];

   logic [1:0]                   action_ff, action_in;
   logic [lphs_pkg::KEY_W-1:0]   key_ff, key_in;
   logic [IDX_W-1:0]             idx_ff, idx_in;
   logic [IDX_W-1:0]             n_ff, n_in;
   logic                         hit_ff, hit_in;
   logic [IDX_W-1:0]             at_ff, at_in;
   logic                         has_free_ff, has_free_in;
   logic [IDX_W-1:0]             free_ff, free_in;
   logic [lphs_pkg::COUNT_W-1:0] count_ff, count_in;
   logic [IDX_W-1:0]             clr_ff, clr_in;
   lphs_pkg::rsp_type            rsp_ff, rsp_in;
   logic                         rsp_valid_ff;

   logic [1:0]                 mark_q;
   logic [lphs_pkg::KEY_W-1:0] key_q;

   logic [IDX_W-1:0] mod_rem;
   logic             mod_done;
   logic [IDX_W-1:0] home;
   logic [IDX_W-1:0] next_idx;
   logic [IDX_W-1:0] rd_addr;
   logic             is_empty, is_full, match, reusable;
   logic             do_add, do_rem, refused;
   logic             mark_we;
   logic [IDX_W-1:0] mark_wa;
   logic [1:0]       mark_wd;

   lphs_mod #(.SLOTS(SLOTS)) u_mod (
      .clock (clock),
      .reset (reset),
      .load  (cmd.accept),
      .key   (req_data.key),
      .rem   (mod_rem),
      .done  (mod_done)
   );

   assign home     = POW2 ? key_ff[IDX_W-1:0] : mod_rem;
   assign next_idx = (idx_ff == LAST_IDX) ? '0 : idx_ff + 1'b1;
   assign rd_addr  = cmd.prime ? home : next_idx;

   // slot check on the data read for idx_ff
   assign is_empty = (mark_q == lphs_pkg::MARK_EMPTY);
   assign is_full  = (mark_q == lphs_pkg::MARK_FULL);
   assign match    = is_full && (key_q == key_ff);
   assign reusable = !is_full && !match;

   assign sts.clear_last = (clr_ff == LAST_IDX);
   assign sts.mod_done   = mod_done;
   assign sts.probe_stop = is_empty || match || (n_ff == LAST_IDX);

   assign do_add  = (action_ff == lphs_pkg::ACT_ADD) && !hit_ff && has_free_ff
                    && (count_ff < load_limit);
   assign do_rem  = (action_ff == lphs_pkg::ACT_REMOVE) && hit_ff;
   assign refused = (action_ff == lphs_pkg::ACT_ADD) && !hit_ff && !do_add;

   always_comb begin
      action_in   = action_ff;
      key_in      = key_ff;
      idx_in      = idx_ff;
      n_in        = n_ff;
      hit_in      = hit_ff;
      at_in       = at_ff;
      has_free_in = has_free_ff;
      free_in     = free_ff;
      count_in    = count_ff;
      clr_in      = clr_ff;
      rsp_in      = rsp_ff;
      if (cmd.clear_step) begin
         clr_in = clr_ff + 1'b1;
      end
      if (cmd.accept) begin
         action_in   = req_data.action;
         key_in      = req_data.key;
         hit_in      = 1'b0;
         has_free_in = 1'b0;
      end
      if (cmd.prime) begin
         idx_in = home;
         n_in   = '0;
      end
      if (cmd.probe) begin
         idx_in = next_idx;
         n_in   = n_ff + 1'b1;
         if (match) begin
            hit_in = 1'b1;
            at_in  = idx_ff;
         end
         if (reusable && !has_free_ff) begin
            has_free_in = 1'b1;
            free_in     = idx_ff;
         end
      end
      if (cmd.finish) begin
         if (do_add) begin
            count_in = count_ff + 1'b1;
         end else if (do_rem) begin
            count_in = count_ff - 1'b1;
         end
         rsp_in.hit     = hit_ff;
         rsp_in.refused = refused;
         rsp_in.count   = count_in;
      end
   end

   always_comb begin
      mark_we = 1'b0;
      mark_wa = free_ff;
      mark_wd = lphs_pkg::MARK_FULL;
      priority if (cmd.clear_step) begin
         mark_we = 1'b1;
         mark_wa = clr_ff;
         mark_wd = lphs_pkg::MARK_EMPTY;
      end else if (cmd.finish && do_add) begin
         mark_we = 1'b1;
      end else if (cmd.finish && do_rem) begin
         mark_we = 1'b1;
         mark_wa = at_ff;
         mark_wd = lphs_pkg::MARK_TOMB;
      end
   end

   always_ff @(posedge clock) begin
      if (mark_we) begin
         marks_mem[mark_wa] <= mark_wd;
      end
      mark_q <= marks_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (cmd.finish && do_add) begin
         keys_mem[free_ff] <= key_ff;
      end
      key_q <= keys_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= cmd.finish;
      end
   end

   always_ff @(posedge clock) begin
      action_ff   <= action_in;
      key_ff      <= key_in;
      idx_ff      <= idx_in;
      n_ff        <= n_in;
      hit_ff      <= hit_in;
      at_ff       <= at_in;
      has_free_ff <= has_free_in;
      free_ff     <= free_in;
      rsp_ff      <= rsp_in;
   end

   assign rsp_data   = rsp_ff;
   assign rsp_strobe = rsp_valid_ff;

endmodule

@@ rtl/core/linear_probe_hash_set.sv @@
// Linear-probing hash set of 32-bit keys. Pulse start with a request word
// (add, remove, contains) while busy is low; exactly one response word comes
// back on rsp_data, marked by rsp_strobe for a single cycle. The receiver
// cannot stall: sample the response in the cycle rsp_strobe is high. The
// next request may be issued in that same cycle.
// Operation: after reset a clearing pass walks the slot-mark memory one slot
// per cycle, and busy stays high until every slot is cleared; CSR writes are
// still taken. A request keeps busy high while it probes one slot per cycle
// (set by the single read port of the slot memories), so requests do not
// overlap. When SLOTS is not a power of two, the home slot comes from a
// reciprocal-multiply remainder unit that runs before the probe walk. The
// unused action code skips the probe walk.
// CSR: load_limit at byte address 0 (11 bits, reset 512). Adds of new keys
// are refused once the element count reaches it.

`include "linear_probe_hash_set_defines.svh"

module linear_probe_hash_set #(
   parameter int SLOTS = lphs_pkg::SLOTS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,

   // request word in
   input  logic                              start,
   output logic                              busy,
   input  lphs_pkg::req_type                 req_data,

   // response word out
   output logic                              rsp_strobe,
   output lphs_pkg::rsp_type                 rsp_data,

   // CSR port
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [lphs_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [lphs_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [lphs_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready
);

   lphs_pkg::cmd_type cmd;
   lphs_pkg::sts_type sts;

   logic [lphs_pkg::COUNT_W-1:0] load_limit_ff, load_limit_in;
   logic                         csr_wr;

   // --- CSR: single register, zero wait states ---
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite
                       && (csr_paddr == lphs_pkg::ADDR_LOAD_LIMIT);

   always_comb begin
      load_limit_in = load_limit_ff;
      if (csr_wr) begin
         load_limit_in = csr_pwdata[lphs_pkg::COUNT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         load_limit_ff <= lphs_pkg::LOAD_LIMIT_RESET;
      end else begin
         load_limit_ff <= load_limit_in;
      end
   end

   // unmapped addresses read as zero
   assign csr_prdata = (csr_paddr == lphs_pkg::ADDR_LOAD_LIMIT)
                       ? lphs_pkg::CSR_DATA_W'(load_limit_ff) : '0;

   // --- sequencer ---
   lphs_ctrl #(.SLOTS(SLOTS)) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_action (req_data.action),
      .sts        (sts),
      .cmd        (cmd),
      .busy       (busy)
   );

   // --- slot memories, probe state, element count ---
   lphs_dp #(.SLOTS(SLOTS)) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .req_data   (req_data),
      .load_limit (load_limit_ff),
      .sts        (sts),
      .rsp_data   (rsp_data),
      .rsp_strobe (rsp_strobe)
   );

   // --- checks ---
   // a word is either a hit or a refused add, never both
   `LPHS_ASSERT_IMP(a_hit_refused_excl, clock, reset, rsp_strobe, !(rsp_data.hit && rsp_data.refused))
   // an accepted request keeps the block busy on the next cycle
   `LPHS_ASSERT_NXT(a_accept_busy, clock, reset, start && !busy, busy)
   // one request in flight: responses are never on adjacent cycles
   `LPHS_ASSERT_NXT(a_rsp_spaced, clock, reset, rsp_strobe, !rsp_strobe)
   // the response cycle always finds the sequencer back in idle
   `LPHS_ASSERT_IMP(a_rsp_idle, clock, reset, rsp_strobe, !busy)

endmodule

@@ tb/tb.sv @@
module tb;
   import lphs_pkg::*;

   // Cycles with no accepted word, response or CSR access before the run is
   // declared hung. The slowest legal gap is the post-reset clear or a
   // full-table probe plus a sender gap, so this leaves plenty of margin.
   localparam int HANG_LIMIT = 10000;

   // Predictor and response ledger for the hash set.
   class hash_set_checker;
      bit [KEY_W-1:0]   slot_key  [SLOTS_DEFAULT];
      bit [1:0]         slot_mark [SLOTS_DEFAULT];
      bit [COUNT_W-1:0] held;
      bit [COUNT_W-1:0] load_limit;
      rsp_type          awaited_rsp [$];
      int               errors;

      function new();
         foreach (slot_mark[i]) slot_mark[i] = MARK_EMPTY;
         held       = '0;
         load_limit = LOAD_LIMIT_RESET;
         errors     = 0;
      endfunction

      function int pending();
         return awaited_rsp.size();
      endfunction

      task report_mismatch(input string what);
         $display("%0t ERROR %s", $time, what);
         errors++;
      endtask

      // Walk the probe sequence for one request word and queue its response.
      function void note_request(input req_type w);
         int unsigned idx;
         int unsigned n;
         int unsigned at_slot;
         int unsigned free_slot;
         bit          found;
         bit          has_free;
         rsp_type     e;
         e         = '0;
         found     = 1'b0;
         has_free  = 1'b0;
         at_slot   = 0;
         free_slot = 0;
         if (w.action != ACT_NONE) begin
            idx = w.key % SLOTS_DEFAULT;
            for (n = 0; n < SLOTS_DEFAULT; n++) begin
               if (slot_mark[idx] == MARK_EMPTY) begin
                  if (!has_free) begin
                     has_free  = 1'b1;
                     free_slot = idx;
                  end
                  break;
               end
               if (slot_mark[idx] == MARK_FULL) begin
                  if (slot_key[idx] == w.key) begin
                     found   = 1'b1;
                     at_slot = idx;
                     break;
                  end
               end else if (!has_free) begin
                  // tombstone (or the unused mark code): first reusable slot
                  has_free  = 1'b1;
                  free_slot = idx;
               end
               idx = (idx + 1) % SLOTS_DEFAULT;
            end
            if (w.action == ACT_ADD && !found) begin
               if (held >= load_limit || !has_free) begin
                  e.refused = 1'b1;
               end else begin
                  slot_key[free_slot]  = w.key;
                  slot_mark[free_slot] = MARK_FULL;
                  held                 = held + 1'b1;
               end
            end else if (w.action == ACT_REMOVE && found) begin
               slot_mark[at_slot] = MARK_TOMB;
               held               = held - 1'b1;
            end
         end
         e.hit   = found;
         e.count = held;
         awaited_rsp.push_back(e);
      endfunction

      task check_reply(input rsp_type got);
         rsp_type e;
         if (awaited_rsp.size() == 0) begin
            report_mismatch($sformatf("response word with none outstanding: %h", got));
         end else begin
            e = awaited_rsp.pop_front();
            if (got.hit !== e.hit)
               report_mismatch($sformatf("hit %b, want %b", got.hit, e.hit));
            if (got.refused !== e.refused)
               report_mismatch($sformatf("refused %b, want %b", got.refused, e.refused));
            if (got.count !== e.count)
               report_mismatch($sformatf("count %0d, want %0d", got.count, e.count));
         end
      endtask
   endclass

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  start       = 1'b0;
   logic                  busy;
   req_type               req_data    = '0;
   logic                  rsp_strobe;
   rsp_type               rsp_data;
   logic                  csr_psel    = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata  = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   hash_set_checker sb = new();
   int              quiet_cycles = 0;

   // keys the random phases draw from; clustered homes force probe chains
   logic [KEY_W-1:0] key_pool [$];

   linear_probe_hash_set dut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_data    (req_data),
      .rsp_strobe  (rsp_strobe),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #4 clock = ~clock;

   // Monitor: check the response first, then log a newly accepted word, so a
   // response and the next accept on the same edge stay in order.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_strobe) sb.check_reply(rsp_data);
         if (start && !busy) sb.note_request(req_data);
      end
   end

   // Hang detector: any accepted word, response or CSR access resets it.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe || (csr_psel && csr_penable))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= HANG_LIMIT) begin
         $display("linear_probe_hash_set: mismatch");
         $finish;
      end
   end

   // Sender gap: geometric, pct is the chance of idling each cycle.
   function automatic int idle_gap(input int pct);
      int g;
      g = 0;
      while (g < 40 && $urandom_range(0, 99) < pct) g++;
      return g;
   endfunction

   // Drive one request word; start stays high afterwards so back-to-back
   // words never see start dropped and raised in the same step.
   task automatic send_word(input logic [1:0] act, input logic [KEY_W-1:0] k, input int gap);
      req_type w;
      w.action = act;
      w.key    = k;
      repeat (gap) begin
         @(negedge clock);
         start <= 1'b0;
      end
      @(negedge clock);
      start    <= 1'b1;
      req_data <= w;
      do @(posedge clock); while (busy);
   endtask

   // Stop sending and wait until every outstanding response has come back.
   task automatic drain_replies();
      @(negedge clock);
      start <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   // One APB transfer on the load_limit register: setup, then access.
   task automatic csr_access(input bit wr, input logic [CSR_DATA_W-1:0] wdata,
                             output logic [CSR_DATA_W-1:0] rdata);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= ADDR_LOAD_LIMIT;
      csr_pwdata  <= wdata;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rdata = csr_prdata;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // Write load_limit, read it back, and update the predictor.
   task automatic set_load_limit(input logic [COUNT_W-1:0] value);
      logic [CSR_DATA_W-1:0] rd;
      csr_access(1'b1, {{(CSR_DATA_W-COUNT_W){1'b0}}, value}, rd);
      sb.load_limit = value;
      csr_access(1'b0, '0, rd);
      if (rd !== {{(CSR_DATA_W-COUNT_W){1'b0}}, value})
         sb.report_mismatch($sformatf("load_limit reads %h, want %h", rd, value));
   endtask

   // Fresh pool: keys share a narrow band of home slots, sometimes near the
   // top of the table so probes wrap.
   function automatic void build_pool(input int n);
      int unsigned      base;
      int unsigned      home;
      logic [KEY_W-1:0] r;
      key_pool.delete();
      base = ($urandom_range(0, 1) != 0) ? 1012 : $urandom_range(0, SLOTS_DEFAULT - 1);
      repeat (n) begin
         home = (base + $urandom_range(0, 23)) % SLOTS_DEFAULT;
         r    = $urandom();
         key_pool.push_back({r[KEY_W-1:10], home[9:0]});
      end
   endfunction

   function automatic logic [KEY_W-1:0] pick_key();
      int               r;
      logic [KEY_W-1:0] k;
      r = $urandom_range(0, 99);
      k = key_pool[$urandom_range(0, key_pool.size() - 1)];
      if (r >= 85)
         k = $urandom();                       // almost surely absent
      else if (r >= 75)
         k = k ^ ({$urandom()} << 10);         // same home, different key
      return k;
   endfunction

   // Mostly pool keys so adds, removes and lookups interact; now and then
   // the sender holds off until the block is fully drained.
   task automatic random_phase(input int items, input int pct);
      int         done;
      int         r;
      logic [1:0] act;
      done = 0;
      while (done < items) begin
         r   = $urandom_range(0, 99);
         act = (r < 40) ? ACT_ADD : (r < 65) ? ACT_REMOVE : (r < 95) ? ACT_CONTAINS : ACT_NONE;
         send_word(act, pick_key(), idle_gap(pct));
         if (act != ACT_NONE) done++;
         if ($urandom_range(0, 99) < 3) drain_replies();
      end
      drain_replies();
      repeat (4) @(posedge clock);
   endtask

   initial begin : main
      logic [CSR_DATA_W-1:0] rd;

      repeat (9) @(negedge clock);
      reset <= 1'b0;

      // reset value of load_limit; the block is still clearing its marks
      csr_access(1'b0, '0, rd);
      if (rd !== {{(CSR_DATA_W-COUNT_W){1'b0}}, LOAD_LIMIT_RESET})
         sb.report_mismatch($sformatf("load_limit resets to %h", rd));

      // Directed words at load_limit 512, back to back.
      send_word(ACT_CONTAINS, 32'h0000_0000, 0);   // lookup in an empty table
      send_word(ACT_ADD,      32'h0000_0000, 0);
      send_word(ACT_ADD,      32'h0000_0000, 0);   // already present: no change
      send_word(ACT_ADD,      32'hFFFF_FFFF, 0);   // home is the top slot
      send_word(ACT_ADD,      32'h0000_07FF, 0);   // same home, probe wraps to 0, 1
      send_word(ACT_CONTAINS, 32'h0000_07FF, 0);
      send_word(ACT_REMOVE,   32'hFFFF_FFFF, 0);   // leaves a tombstone on top
      send_word(ACT_CONTAINS, 32'h0000_07FF, 0);   // search runs past the tombstone
      send_word(ACT_ADD,      32'hFFFF_FBFF, 0);   // reuses that tombstone
      send_word(ACT_REMOVE,   32'h1234_5678, 0);   // remove of an absent key
      send_word(ACT_NONE,     32'hAAAA_5555, 0);   // unused action is ignored
      send_word(ACT_NONE,     32'h0000_0000, 0);
      send_word(ACT_REMOVE,   32'h0000_0000, 0);
      send_word(ACT_CONTAINS, 32'h0000_0000, 0);
      send_word(ACT_ADD,      32'h0000_0000, 0);   // back into the slot-0 tombstone
      send_word(ACT_CONTAINS, 32'hFFFF_FBFF, 0);
      send_word(ACT_CONTAINS, 32'h8000_0000, 0);   // home 0, absent, probes a chain
      send_word(ACT_REMOVE,   32'h0000_07FF, 0);
      drain_replies();
      repeat (4) @(posedge clock);

      // Random phases at several limits and sender idle rates.
      set_load_limit(11'd1024);
      build_pool(48);
      random_phase(250, 0);

      set_load_limit(11'd1);                       // adds of new keys mostly refused
      random_phase(90, 70);

      set_load_limit(11'd0);                       // every add of a new key refused
      random_phase(60, 16);

      // limit far above any count the pool can reach
      set_load_limit(11'd2047);
      random_phase(120, 16);

      set_load_limit(11'd1024);
      random_phase(200, 70);

      set_load_limit(11'd512);
      build_pool(48);
      random_phase(180, 0);

      // Everything is back; give the block a few more cycles to misbehave.
      drain_replies();
      repeat (40) @(posedge clock);
      if (sb.pending() != 0)
         sb.report_mismatch($sformatf("%0d responses never arrived", sb.pending()));
      if (sb.errors == 0)
         $display("linear_probe_hash_set: match");
      else
         $display("linear_probe_hash_set: mismatch");
      $finish;
   end

endmodule

@@ files.f @@
+incdir+rtl/core
rtl/core/lphs_pkg.sv
rtl/core/lphs_mod.sv
rtl/core/lphs_ctrl.sv
rtl/core/lphs_dp.sv
rtl/core/linear_probe_hash_set.sv
tb/tb.sv
